// ===== src/script_vm_execute_unit_defines.svh =====
`ifndef SCRIPT_VM_EXECUTE_UNIT_DEFINES_SVH
`define SCRIPT_VM_EXECUTE_UNIT_DEFINES_SVH

// condition must hold on the same edge as the trigger
`define SVMX_ASSERT_NOW(lbl, ant, con) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (con)) \
    else $error("svmx port check failed");

// condition must hold on the edge after the trigger
`define SVMX_ASSERT_NEXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (con)) \
    else $error("svmx port check failed");

`endif

// ===== src/svmx_pkg.sv =====
package svmx_pkg;

  // default sizes of the storage
  localparam int unsigned DEF_NUM_VARS    = 64;
  localparam int unsigned DEF_CALL_DEPTH  = 16;
  localparam int unsigned DEF_ARENA_WORDS = 1024;
  localparam int unsigned MAX_LINES       = 1024;

  // field widths
  localparam int unsigned DATA_W    = 64;
  localparam int unsigned PC_W      = 11;
  localparam int unsigned KIND_W    = 4;
  localparam int unsigned CMP_W     = 3;
  localparam int unsigned TGT_W     = 10;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned CFG_IDX_W = 8;

  // xorshift64 shift amounts
  localparam int unsigned XS_A = 13;
  localparam int unsigned XS_B = 7;
  localparam int unsigned XS_C = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROGRAM_LINES = 8'd0,
    CFG_RNG_SEED      = 8'd1
  } cfg_idx_e;

  typedef enum logic [KIND_W-1:0] {
    K_SET    = 4'd0,
    K_ADD    = 4'd1,
    K_SUB    = 4'd2,
    K_MUL    = 4'd3,
    K_DIV    = 4'd4,
    K_RND    = 4'd5,
    K_GOTO   = 4'd6,
    K_GOSUB  = 4'd7,
    K_RETURN = 4'd8,
    K_IF     = 4'd9,
    K_ALLOC  = 4'd10,
    K_POKE   = 4'd11,
    K_PEEK   = 4'd12,
    K_FLIP   = 4'd13,
    K_END    = 4'd14,
    K_NOP    = 4'd15
  } kind_e;

  typedef enum logic [CMP_W-1:0] {
    CMP_EQ = 3'd0,
    CMP_NE = 3'd1,
    CMP_LT = 3'd2,
    CMP_GT = 3'd3,
    CMP_LE = 3'd4,
    CMP_GE = 3'd5
  } cmp_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_CONT     = 2'd0,
    ST_YIELD    = 2'd1,
    ST_ENDED    = 2'd2,
    ST_CALL_ERR = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_FETCH_A,
    S_FETCH_B,
    S_FETCH_C,
    S_FETCH_W,
    S_EXEC,
    S_WAIT,
    S_PEEK,
    S_WB
  } state_e;

  typedef enum logic [1:0] {
    RD_A,
    RD_B,
    RD_C
  } rd_sel_e;

  // controller to datapath
  typedef struct packed {
    logic    clr_en;
    logic    take_in;
    rd_sel_e rd_sel;
    logic    cap_a;
    logic    cap_b;
    logic    cap_c;
    logic    exec;
    logic    peek_cap;
    logic    wb;
    logic    load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_done;
    logic long_op;
    logic peek_op;
    logic unit_done;
  } sts_t;

  function automatic logic [DATA_W-1:0] xorshift64(input logic [DATA_W-1:0] s);
    logic [DATA_W-1:0] t;
    t = s ^ (s << XS_A);
    t = t ^ (t >> XS_B);
    t = t ^ (t << XS_C);
    return t;
  endfunction

endpackage

// ===== src/svmx_div.sv =====
module svmx_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [svmx_pkg::DATA_W-1:0] dividend_i,
  input  logic [svmx_pkg::DATA_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [svmx_pkg::DATA_W-1:0] quotient_o,
  output logic [svmx_pkg::DATA_W-1:0] remainder_o
);
  import svmx_pkg::*;

  localparam int unsigned CNT_W = $clog2(DATA_W);

  logic              busy_q, done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DATA_W-1:0] rem_q, quo_q, dsr_q;
  logic [DATA_W:0]   diff;

  // one restoring step per cycle
  assign diff = {rem_q, quo_q[DATA_W-1]} - {1'b0, dsr_q};

  // step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(DATA_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // partial remainder and quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      if (!diff[DATA_W]) begin
        rem_q <= diff[DATA_W-1:0];
        quo_q <= {quo_q[DATA_W-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[DATA_W-2:0], quo_q[DATA_W-1]};
        quo_q <= {quo_q[DATA_W-2:0], 1'b0};
      end
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// ===== src/svmx_ctrl.sv =====
module svmx_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  svmx_pkg::sts_t sts_i,
  output svmx_pkg::cmd_t cmd_o
);
  import svmx_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR:   if (sts_i.clr_done) state_d = S_IDLE;
      S_IDLE:    if (in_valid_i) state_d = S_FETCH_A;
      S_FETCH_A: state_d = S_FETCH_B;
      S_FETCH_B: state_d = S_FETCH_C;
      S_FETCH_C: state_d = S_FETCH_W;
      S_FETCH_W: state_d = S_EXEC;
      S_EXEC: begin
        if (sts_i.long_op) state_d = S_WAIT;
        else if (sts_i.peek_op) state_d = S_PEEK;
        else state_d = S_WB;
      end
      S_WAIT:    if (sts_i.unit_done) state_d = S_WB;
      S_PEEK:    state_d = S_WB;
      S_WB:      if (out_free) state_d = S_IDLE;
      default:   state_d = S_CLEAR;
    endcase
  end

  // commands
  always_comb begin
    cmd_o = '0;
    cmd_o.rd_sel = RD_A;
    case (state_q)
      S_CLEAR:   cmd_o.clr_en = 1'b1;
      S_IDLE:    cmd_o.take_in = in_valid_i;
      S_FETCH_A: cmd_o.rd_sel = RD_A;
      S_FETCH_B: begin
        cmd_o.rd_sel = RD_B;
        cmd_o.cap_a  = 1'b1;
      end
      S_FETCH_C: begin
        cmd_o.rd_sel = RD_C;
        cmd_o.cap_b  = 1'b1;
      end
      S_FETCH_W: cmd_o.cap_c = 1'b1;
      S_EXEC:    cmd_o.exec = 1'b1;
      S_PEEK:    cmd_o.peek_cap = 1'b1;
      S_WB: begin
        cmd_o.wb       = 1'b1;
        cmd_o.load_out = out_free;
      end
      default:   cmd_o.rd_sel = RD_A;
    endcase
  end

  // result beat valid
  always_comb begin
    if (cmd_o.load_out) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== src/svmx_dp.sv =====
module svmx_dp #(
  parameter int unsigned NUM_VARS    = svmx_pkg::DEF_NUM_VARS,
  parameter int unsigned CALL_DEPTH  = svmx_pkg::DEF_CALL_DEPTH,
  parameter int unsigned ARENA_WORDS = svmx_pkg::DEF_ARENA_WORDS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  svmx_pkg::cmd_t                    cmd_i,
  output svmx_pkg::sts_t                    sts_o,
  input  logic                              cfg_we_i,
  input  logic [svmx_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [svmx_pkg::DATA_W-1:0]       cfg_data_i,
  input  logic [svmx_pkg::KIND_W-1:0]       kind_i,
  input  logic                              a_is_var_i,
  input  logic signed [svmx_pkg::DATA_W-1:0] a_value_i,
  input  logic                              b_is_var_i,
  input  logic signed [svmx_pkg::DATA_W-1:0] b_value_i,
  input  logic                              c_is_var_i,
  input  logic signed [svmx_pkg::DATA_W-1:0] c_value_i,
  input  logic [svmx_pkg::CMP_W-1:0]        cmp_code_i,
  input  logic                              negate_i,
  input  logic [svmx_pkg::TGT_W-1:0]        target_line_i,
  output logic [svmx_pkg::PC_W-1:0]         next_pc_o,
  output logic [svmx_pkg::STATUS_W-1:0]     status_o,
  output logic signed [svmx_pkg::DATA_W-1:0] written_value_o
);
  import svmx_pkg::*;

  localparam int unsigned VIDX_W  = $clog2(NUM_VARS);
  localparam int unsigned SIDX_W  = (CALL_DEPTH > 1) ? $clog2(CALL_DEPTH) : 1;
  localparam int unsigned DEPTH_W = $clog2(CALL_DEPTH + 1);
  localparam int unsigned AIDX_W  = $clog2(ARENA_WORDS);
  localparam int unsigned USED_W  = $clog2(ARENA_WORDS + 1);
  localparam int unsigned CLR_N   = (NUM_VARS > ARENA_WORDS) ? NUM_VARS : ARENA_WORDS;
  localparam int unsigned CLR_W   = $clog2(CLR_N + 1);

  // storage
  logic [DATA_W-1:0] var_mem   [NUM_VARS];
  logic [DATA_W-1:0] arena_mem [ARENA_WORDS];
  logic [PC_W-1:0]   stack_mem [CALL_DEPTH];

  // architectural state
  logic [PC_W-1:0]    pc_q;
  logic [PC_W-1:0]    lines_q;
  logic [DEPTH_W-1:0] depth_q;
  logic [USED_W-1:0]  used_q;
  logic [DATA_W-1:0]  rng_q;
  logic [CLR_W-1:0]   clr_q;

  // latched instruction
  logic [KIND_W-1:0] kind_q;
  logic              a_var_q, b_var_q, c_var_q, negate_q;
  logic [DATA_W-1:0] a_q, b_q, c_q;
  logic [CMP_W-1:0]  cmp_q;
  logic [TGT_W-1:0]  tgt_q;

  // operand fetch
  logic [VIDX_W-1:0] rd_idx;
  logic [DATA_W-1:0] var_rd_q, ra_q, rb_q, rc_q;
  logic              a_ok, b_ok, c_ok;

  // execute
  logic [DATA_W-1:0]  old, opa, opb, opc, addr, rng_new, amt, room, un, ud;
  logic               active, addr_ok, rnd_ok, alloc_ok, hit;
  logic [PC_W-1:0]    pc_inc, npc, stack_rd_q;
  logic [DEPTH_W-1:0] depth_m1;
  status_e            st;
  logic [DATA_W-1:0]  res_fast;
  logic               we, dok, push, pop, alloc_go, poke_go, rng_go, div_go, div_rem, mul_go;
  logic [VIDX_W-1:0]  dest;
  logic [DATA_W-1:0]  div_dvd, div_dsr;

  // result
  logic [DATA_W-1:0] res_q, arena_rd_q;
  logic              we_q, dest_ok_q, peek_ok_q, rem_mode_q, dneg_q;
  logic [VIDX_W-1:0] dest_q;
  status_e           status_q;

  // multiplier and divider
  logic              mbusy_q, mul_done;
  logic [1:0]        mstep_q;
  logic [31:0]       mul_x, mul_y;
  logic [DATA_W-1:0] mul_p, prod_q, acc_q;
  logic              div_done;
  logic [DATA_W-1:0] quo, rem;

  // var file and arena write ports
  logic              vw_en;
  logic [VIDX_W-1:0] vw_idx;
  logic [DATA_W-1:0] vw_data;
  logic              aw_en;
  logic [AIDX_W-1:0] aw_idx;
  logic [DATA_W-1:0] aw_data;
  logic              clr_var, clr_arena;

  // input beat capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_in) begin
      kind_q   <= kind_i;
      a_var_q  <= a_is_var_i;
      a_q      <= a_value_i;
      b_var_q  <= b_is_var_i;
      b_q      <= b_value_i;
      c_var_q  <= c_is_var_i;
      c_q      <= c_value_i;
      cmp_q    <= cmp_code_i;
      negate_q <= negate_i;
      tgt_q    <= target_line_i;
    end
  end

  assign a_ok = (a_q < DATA_W'(NUM_VARS));
  assign b_ok = (b_q < DATA_W'(NUM_VARS));
  assign c_ok = (c_q < DATA_W'(NUM_VARS));

  // var file read address
  always_comb begin
    case (cmd_i.rd_sel)
      RD_A:    rd_idx = a_q[VIDX_W-1:0];
      RD_B:    rd_idx = b_q[VIDX_W-1:0];
      RD_C:    rd_idx = c_q[VIDX_W-1:0];
      default: rd_idx = a_q[VIDX_W-1:0];
    endcase
  end

  // operand capture, out of range reads give zero
  always_ff @(posedge clk_i) begin
    var_rd_q <= var_mem[rd_idx];
    if (cmd_i.cap_a) ra_q <= a_ok ? var_rd_q : '0;
    if (cmd_i.cap_b) rb_q <= b_ok ? var_rd_q : '0;
    if (cmd_i.cap_c) rc_q <= c_ok ? var_rd_q : '0;
  end

  assign old = ra_q;
  assign opa = a_var_q ? ra_q : a_q;
  assign opb = b_var_q ? rb_q : b_q;
  assign opc = c_var_q ? rc_q : c_q;

  // shared execute terms
  assign active   = (32'(pc_q) < 32'(lines_q)) && (32'(pc_q) < 32'(MAX_LINES));
  assign pc_inc   = pc_q + PC_W'(1);
  assign depth_m1 = depth_q - DEPTH_W'(1);
  assign addr     = opa + opb;
  assign addr_ok  = !addr[DATA_W-1] && (addr != '0) && (addr < DATA_W'(used_q))
                    && (addr < DATA_W'(ARENA_WORDS));
  assign rng_new  = xorshift64(rng_q);
  assign rnd_ok   = (opb != '0) && !opb[DATA_W-1];
  assign amt      = (opb[DATA_W-1] || opb == '0) ? DATA_W'(1) : opb;
  assign room     = DATA_W'(ARENA_WORDS) - DATA_W'(used_q);
  assign alloc_ok = !(amt > room);
  assign un       = old[DATA_W-1] ? (DATA_W'(0) - old) : old;
  assign ud       = opb[DATA_W-1] ? (DATA_W'(0) - opb) : opb;

  // branch condition
  always_comb begin
    case (cmp_e'(cmp_q))
      CMP_EQ:  hit = (opa == opb);
      CMP_NE:  hit = (opa != opb);
      CMP_LT:  hit = ($signed(opa) < $signed(opb));
      CMP_GT:  hit = ($signed(opa) > $signed(opb));
      CMP_LE:  hit = ($signed(opa) <= $signed(opb));
      CMP_GE:  hit = ($signed(opa) >= $signed(opb));
      default: hit = 1'b0;
    endcase
    hit = hit ^ negate_q;
  end

  // instruction decode and results that need no unit
  always_comb begin
    npc      = pc_q;
    st       = ST_CONT;
    res_fast = '0;
    we       = 1'b0;
    dest     = a_q[VIDX_W-1:0];
    dok      = a_ok;
    push     = 1'b0;
    pop      = 1'b0;
    alloc_go = 1'b0;
    poke_go  = 1'b0;
    rng_go   = 1'b0;
    div_go   = 1'b0;
    div_rem  = 1'b0;
    div_dvd  = un;
    div_dsr  = ud;
    mul_go   = 1'b0;
    if (!active) begin
      st = ST_ENDED;
    end else begin
      case (kind_e'(kind_q))
        K_SET: begin
          res_fast = opb;
          we = 1'b1;
          npc = pc_inc;
        end
        K_ADD: begin
          res_fast = old + opb;
          we = 1'b1;
          npc = pc_inc;
        end
        K_SUB: begin
          res_fast = old - opb;
          we = 1'b1;
          npc = pc_inc;
        end
        K_MUL: begin
          we = 1'b1;
          npc = pc_inc;
          mul_go = 1'b1;
        end
        K_DIV: begin
          we = 1'b1;
          npc = pc_inc;
          div_go = (opb != '0);
        end
        K_RND: begin
          we = 1'b1;
          npc = pc_inc;
          if (rnd_ok) begin
            rng_go  = 1'b1;
            div_go  = 1'b1;
            div_rem = 1'b1;
            div_dvd = rng_new;
            div_dsr = opb;
          end
        end
        K_GOTO: npc = PC_W'(tgt_q);
        K_GOSUB: begin
          if (depth_q == DEPTH_W'(CALL_DEPTH)) begin
            st = ST_CALL_ERR;
          end else begin
            push = 1'b1;
            npc = PC_W'(tgt_q);
          end
        end
        K_RETURN: begin
          if (depth_q == '0) begin
            st = ST_CALL_ERR;
          end else begin
            pop = 1'b1;
            npc = stack_rd_q;
          end
        end
        K_IF: npc = hit ? PC_W'(tgt_q) : pc_inc;
        K_ALLOC: begin
          we = 1'b1;
          npc = pc_inc;
          if (alloc_ok) begin
            res_fast = DATA_W'(used_q);
            alloc_go = 1'b1;
          end else begin
            res_fast = '1;
          end
        end
        K_POKE: begin
          npc = pc_inc;
          poke_go = addr_ok;
        end
        K_PEEK: begin
          we = 1'b1;
          dest = c_q[VIDX_W-1:0];
          dok = c_ok;
          npc = pc_inc;
        end
        K_FLIP: begin
          npc = pc_inc;
          st = ST_YIELD;
        end
        K_END:   st = ST_ENDED;
        default: npc = pc_inc;
      endcase
    end
  end

  assign sts_o.long_op   = mul_go || div_go;
  assign sts_o.peek_op   = active && (kind_q == K_PEEK);
  assign sts_o.unit_done = mul_done || div_done;
  assign sts_o.clr_done  = (clr_q == CLR_W'(CLR_N));

  // clear sweep after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_en && !sts_o.clr_done) begin
      clr_q <= clr_q + CLR_W'(1);
    end
  end

  assign clr_var   = cmd_i.clr_en && (32'(clr_q) < 32'(NUM_VARS));
  assign clr_arena = cmd_i.clr_en && (32'(clr_q) < 32'(ARENA_WORDS));

  // control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q    <= '0;
      lines_q <= '0;
      depth_q <= '0;
      used_q  <= USED_W'(1);
      rng_q   <= DATA_W'(1);
    end else begin
      if (cfg_we_i && cfg_index_i == CFG_PROGRAM_LINES) lines_q <= cfg_data_i[PC_W-1:0];
      if (cfg_we_i && cfg_index_i == CFG_RNG_SEED) rng_q <= cfg_data_i | DATA_W'(1);
      if (cmd_i.exec) begin
        pc_q <= npc;
        if (push) depth_q <= depth_q + DEPTH_W'(1);
        else if (pop) depth_q <= depth_m1;
        if (alloc_go) used_q <= used_q + amt[USED_W-1:0];
        if (rng_go) rng_q <= rng_new;
      end
    end
  end

  // call stack
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && push) stack_mem[depth_q[SIDX_W-1:0]] <= pc_inc;
    stack_rd_q <= stack_mem[depth_m1[SIDX_W-1:0]];
  end

  // arena port
  always_comb begin
    aw_en   = clr_arena || (cmd_i.exec && poke_go);
    aw_idx  = clr_arena ? clr_q[AIDX_W-1:0] : addr[AIDX_W-1:0];
    aw_data = clr_arena ? '0 : opc;
  end

  always_ff @(posedge clk_i) begin
    if (aw_en) arena_mem[aw_idx] <= aw_data;
    arena_rd_q <= arena_mem[addr[AIDX_W-1:0]];
  end

  // var file port
  always_comb begin
    vw_en   = clr_var || (cmd_i.wb && we_q && dest_ok_q);
    vw_idx  = clr_var ? clr_q[VIDX_W-1:0] : dest_q;
    vw_data = clr_var ? '0 : res_q;
  end

  always_ff @(posedge clk_i) begin
    if (vw_en) var_mem[vw_idx] <= vw_data;
  end

  // 64x64 low product from three 32x32 partial products
  always_comb begin
    mul_x = (mstep_q == 2'd1) ? old[DATA_W-1:32] : old[31:0];
    mul_y = (mstep_q == 2'd2) ? opb[DATA_W-1:32] : opb[31:0];
  end

  assign mul_p    = mul_x * mul_y;
  assign mul_done = mbusy_q && (mstep_q == 2'd3);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mbusy_q <= 1'b0;
      mstep_q <= '0;
    end else if (cmd_i.exec && mul_go) begin
      mbusy_q <= 1'b1;
      mstep_q <= '0;
    end else if (mbusy_q) begin
      mstep_q <= mstep_q + 2'd1;
      if (mul_done) mbusy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    if (mstep_q == 2'd1) acc_q <= prod_q;
    else if (mstep_q == 2'd2) acc_q <= acc_q + {prod_q[31:0], 32'b0};
  end

  svmx_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.exec && div_go),
    .dividend_i  (div_dvd),
    .divisor_i   (div_dsr),
    .done_o      (div_done),
    .quotient_o  (quo),
    .remainder_o (rem)
  );

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      res_q      <= res_fast;
      we_q       <= we;
      dest_q     <= dest;
      dest_ok_q  <= dok;
      status_q   <= st;
      peek_ok_q  <= addr_ok;
      rem_mode_q <= div_rem;
      dneg_q     <= old[DATA_W-1] ^ opb[DATA_W-1];
    end else if (cmd_i.peek_cap) begin
      res_q <= peek_ok_q ? arena_rd_q : '0;
    end else if (mul_done) begin
      res_q <= acc_q + {prod_q[31:0], 32'b0};
    end else if (div_done) begin
      if (rem_mode_q) res_q <= rem;
      else res_q <= dneg_q ? (DATA_W'(0) - quo) : quo;
    end
  end

  // output beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      next_pc_o       <= pc_q;
      status_o        <= status_q;
      written_value_o <= (we_q && dest_ok_q) ? $signed(res_q) : '0;
    end
  end

endmodule

// ===== src/script_vm_execute_unit.sv =====
// result path: fetch, execute and write back, with a peek state for peek and a
//   wait on the unit for mul, div and rnd (radix-2 divider, one quotient bit a cycle)
// flow: one instruction in flight; the next beat is taken the cycle after
//   its result is queued
// reset: async active low; then a clear sweep zeroes the var file and arena,
//   with no input beat taken until done
module script_vm_execute_unit #(
  parameter int unsigned NUM_VARS    = svmx_pkg::DEF_NUM_VARS,
  parameter int unsigned CALL_DEPTH  = svmx_pkg::DEF_CALL_DEPTH,
  parameter int unsigned ARENA_WORDS = svmx_pkg::DEF_ARENA_WORDS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [svmx_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [svmx_pkg::DATA_W-1:0]        cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [svmx_pkg::KIND_W-1:0]        kind_i,
  input  logic                               a_is_var_i,
  input  logic signed [svmx_pkg::DATA_W-1:0] a_value_i,
  input  logic                               b_is_var_i,
  input  logic signed [svmx_pkg::DATA_W-1:0] b_value_i,
  input  logic                               c_is_var_i,
  input  logic signed [svmx_pkg::DATA_W-1:0] c_value_i,
  input  logic [svmx_pkg::CMP_W-1:0]         cmp_code_i,
  input  logic                               negate_i,
  input  logic [svmx_pkg::TGT_W-1:0]         target_line_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [svmx_pkg::PC_W-1:0]          next_pc_o,
  output logic [svmx_pkg::STATUS_W-1:0]      status_o,
  output logic signed [svmx_pkg::DATA_W-1:0] written_value_o
);
  import svmx_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // the user must write registers only between instructions; the block does not enforce it
  assign cfg_ready_o = 1'b1;

  svmx_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  svmx_dp #(
    .NUM_VARS    (NUM_VARS),
    .CALL_DEPTH  (CALL_DEPTH),
    .ARENA_WORDS (ARENA_WORDS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .kind_i          (kind_i),
    .a_is_var_i      (a_is_var_i),
    .a_value_i       (a_value_i),
    .b_is_var_i      (b_is_var_i),
    .b_value_i       (b_value_i),
    .c_is_var_i      (c_is_var_i),
    .c_value_i       (c_value_i),
    .cmp_code_i      (cmp_code_i),
    .negate_i        (negate_i),
    .target_line_i   (target_line_i),
    .next_pc_o       (next_pc_o),
    .status_o        (status_o),
    .written_value_o (written_value_o)
  );

endmodule

// ===== src/svmx_checker.sv =====
`include "script_vm_execute_unit_defines.svh"

module svmx_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic [svmx_pkg::PC_W-1:0]          next_pc_o,
  input logic [svmx_pkg::STATUS_W-1:0]      status_o,
  input logic signed [svmx_pkg::DATA_W-1:0] written_value_o
);
  import svmx_pkg::*;

  // a stalled result beat stays put
  `SVMX_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)
  `SVMX_ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i, $stable(next_pc_o) && $stable(status_o) && $stable(written_value_o))

  // one instruction in flight at a time
  `SVMX_ASSERT_NEXT(a_one_at_a_time, in_valid_i && in_ready_o, !in_ready_o)

  // yield, end and stack errors write no variable
  `SVMX_ASSERT_NOW(a_no_write_on_stop, out_valid_o && (status_o != ST_CONT), written_value_o == '0)

endmodule

bind script_vm_execute_unit svmx_checker u_svmx_checker (.*);

// ===== tb/tb_script_vm_execute_unit.sv =====
module tb_script_vm_execute_unit;
  import svmx_pkg::*;

  localparam int unsigned NVARS      = DEF_NUM_VARS;
  localparam int unsigned STACK_SZ   = DEF_CALL_DEPTH;
  localparam int unsigned ARENA_SZ   = DEF_ARENA_WORDS;
  localparam int unsigned SETTLE     = 100;
  localparam longint      CYCLE_CAP  = 4000000;
  localparam int unsigned RAND_ITEMS = 360;

  typedef struct {
    kind_e             kind;
    logic              a_is_var;
    logic [DATA_W-1:0] a_value;
    logic              b_is_var;
    logic [DATA_W-1:0] b_value;
    logic              c_is_var;
    logic [DATA_W-1:0] c_value;
    logic [CMP_W-1:0]  cmp_code;
    logic              negate;
    logic [TGT_W-1:0]  target_line;
  } instr_t;

  typedef struct {
    logic [PC_W-1:0]     next_pc;
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   written_value;
  } outcome_t;

  // instruction predictor with its own machine state
  class vm_scoreboard;
    logic [PC_W-1:0]   lines_reg;
    logic [PC_W-1:0]   pc;
    logic [DATA_W-1:0] vars [NVARS];
    logic [PC_W-1:0]   ret_stack [STACK_SZ];
    int unsigned       depth;
    logic [DATA_W-1:0] rng;
    logic [DATA_W-1:0] arena [ARENA_SZ];
    logic [DATA_W-1:0] used;
    outcome_t          pending [$];
    int unsigned       errors;

    function new();
      lines_reg = '0;
      pc        = '0;
      foreach (vars[i]) vars[i] = '0;
      foreach (ret_stack[i]) ret_stack[i] = '0;
      foreach (arena[i]) arena[i] = '0;
      depth  = 0;
      rng    = 64'd1;
      used   = 64'd1;
      errors = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [DATA_W-1:0] data);
      if (idx == CFG_PROGRAM_LINES) lines_reg = data[PC_W-1:0];
      else rng = data | 64'd1;
    endfunction

    function logic [DATA_W-1:0] rd(logic [DATA_W-1:0] idx);
      return (idx < NVARS) ? vars[idx] : '0;
    endfunction

    function logic [DATA_W-1:0] wr(logic [DATA_W-1:0] idx, logic [DATA_W-1:0] v);
      if (idx >= NVARS) return '0;
      vars[idx] = v;
      return v;
    endfunction

    function logic [DATA_W-1:0] opnd(logic is_var, logic [DATA_W-1:0] v);
      return is_var ? rd(v) : v;
    endfunction

    // truncating signed divide, zero divisor gives zero
    function logic [DATA_W-1:0] trunc_div(logic [DATA_W-1:0] n, logic [DATA_W-1:0] d);
      logic [DATA_W-1:0] un, ud, q;
      if (d == 0) return '0;
      un = n[DATA_W-1] ? -n : n;
      ud = d[DATA_W-1] ? -d : d;
      q  = un / ud;
      return (n[DATA_W-1] ^ d[DATA_W-1]) ? -q : q;
    endfunction

    function logic arena_ok(logic [DATA_W-1:0] addr);
      return !addr[DATA_W-1] && addr >= 1 && addr < used && addr < ARENA_SZ;
    endfunction

    function void note_input(instr_t it);
      outcome_t          o;
      logic [PC_W-1:0]   lines;
      logic [DATA_W-1:0] bv, old, r, x, y, amt, addr;
      logic              hit;
      lines = (lines_reg < MAX_LINES) ? lines_reg : PC_W'(MAX_LINES);
      o.status        = ST_CONT;
      o.written_value = '0;
      o.next_pc       = pc;
      if (pc >= lines) begin
        o.status = ST_ENDED;
      end else begin
        case (it.kind)
          K_SET, K_ADD, K_SUB, K_MUL, K_DIV, K_RND: begin
            bv  = opnd(it.b_is_var, it.b_value);
            old = rd(it.a_value);
            case (it.kind)
              K_SET:   r = bv;
              K_ADD:   r = old + bv;
              K_SUB:   r = old - bv;
              K_MUL:   r = old * bv;
              K_DIV:   r = trunc_div(old, bv);
              default: begin
                r = '0;
                if (bv != 0 && !bv[DATA_W-1]) begin
                  rng = rng ^ (rng << 13);
                  rng = rng ^ (rng >> 7);
                  rng = rng ^ (rng << 17);
                  r = rng % bv;
                end
              end
            endcase
            o.written_value = wr(it.a_value, r);
            o.next_pc = pc + 1;
          end
          K_GOTO: o.next_pc = it.target_line;
          K_GOSUB: begin
            if (depth >= STACK_SZ) o.status = ST_CALL_ERR;
            else begin
              ret_stack[depth] = pc + 1;
              depth++;
              o.next_pc = it.target_line;
            end
          end
          K_RETURN: begin
            if (depth == 0) o.status = ST_CALL_ERR;
            else begin
              depth--;
              o.next_pc = ret_stack[depth];
            end
          end
          K_IF: begin
            x = opnd(it.a_is_var, it.a_value);
            y = opnd(it.b_is_var, it.b_value);
            case (it.cmp_code)
              CMP_EQ:  hit = (x == y);
              CMP_NE:  hit = (x != y);
              CMP_LT:  hit = ($signed(x) < $signed(y));
              CMP_GT:  hit = ($signed(x) > $signed(y));
              CMP_LE:  hit = ($signed(x) <= $signed(y));
              CMP_GE:  hit = ($signed(x) >= $signed(y));
              default: hit = 1'b0;
            endcase
            if (it.negate) hit = !hit;
            o.next_pc = hit ? PC_W'(it.target_line) : pc + 1;
          end
          K_ALLOC: begin
            amt = opnd(it.b_is_var, it.b_value);
            if (amt[DATA_W-1] || amt == 0) amt = 1;
            if (used > ARENA_SZ || amt > ARENA_SZ - used) begin
              o.written_value = wr(it.a_value, '1);
            end else begin
              o.written_value = wr(it.a_value, used);
              used = used + amt;
            end
            o.next_pc = pc + 1;
          end
          K_POKE: begin
            addr = opnd(it.a_is_var, it.a_value) + opnd(it.b_is_var, it.b_value);
            if (arena_ok(addr)) arena[addr] = opnd(it.c_is_var, it.c_value);
            o.next_pc = pc + 1;
          end
          K_PEEK: begin
            addr = opnd(it.a_is_var, it.a_value) + opnd(it.b_is_var, it.b_value);
            o.written_value = wr(it.c_value, arena_ok(addr) ? arena[addr] : '0);
            o.next_pc = pc + 1;
          end
          K_FLIP: begin
            o.next_pc = pc + 1;
            o.status  = ST_YIELD;
          end
          K_END:   o.status = ST_ENDED;
          default: o.next_pc = pc + 1;
        endcase
      end
      pc = o.next_pc;
      pending.push_back(o);
    endfunction

    function void check_result(logic [PC_W-1:0] npc, logic [STATUS_W-1:0] st,
                               logic [DATA_W-1:0] wv);
      outcome_t e;
      if (pending.size() == 0) begin
        $display("%0t: result beat with nothing expected, pc %0d status %0d value %h",
                 $time, npc, st, wv);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (npc !== e.next_pc) begin
        $display("%0t: next_pc expected %0d actual %0d", $time, e.next_pc, npc);
        errors++;
      end
      if (st !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, st);
        errors++;
      end
      if (wv !== e.written_value) begin
        $display("%0t: written_value expected %h actual %h", $time, e.written_value, wv);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]   cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [KIND_W-1:0]   kind_d = '0;
  logic                a_is_var_d = 1'b0;
  logic [DATA_W-1:0]   a_value_d = '0;
  logic                b_is_var_d = 1'b0;
  logic [DATA_W-1:0]   b_value_d = '0;
  logic                c_is_var_d = 1'b0;
  logic [DATA_W-1:0]   c_value_d = '0;
  logic [CMP_W-1:0]    cmp_code_d = '0;
  logic                negate_d = 1'b0;
  logic [TGT_W-1:0]    target_d = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [PC_W-1:0]     next_pc;
  logic [STATUS_W-1:0] status;
  logic [DATA_W-1:0]   written_value;

  vm_scoreboard sb = new();
  longint      cycles = 0;
  int unsigned burst_left = 0;
  logic [7:0]  stall_pat = 8'hff;

  script_vm_execute_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .kind_i         (kind_d),
    .a_is_var_i     (a_is_var_d),
    .a_value_i      (a_value_d),
    .b_is_var_i     (b_is_var_d),
    .b_value_i      (b_value_d),
    .c_is_var_i     (c_is_var_d),
    .c_value_i      (c_value_d),
    .cmp_code_i     (cmp_code_d),
    .negate_i       (negate_d),
    .target_line_i  (target_d),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .next_pc_o      (next_pc),
    .status_o       (status),
    .written_value_o(written_value)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // result beats, receiver stall pattern and run limit
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
        $display("Mismatches found");
        $finish;
      end else begin
        if (out_valid && out_ready) sb.check_result(next_pc, status, written_value);
        if (cycles % 300 == 0) begin
          case ($urandom_range(0, 3))
            0:       stall_pat <= 8'hff;
            1:       stall_pat <= 8'h01;
            default: stall_pat <= 8'($urandom);
          endcase
        end else begin
          stall_pat <= {stall_pat[0], stall_pat[7:1]};
        end
        out_ready <= stall_pat[0];
      end
    end
  end

  function automatic instr_t mk(kind_e k, logic aiv, logic [DATA_W-1:0] a, logic biv,
                                logic [DATA_W-1:0] b, logic civ = 0,
                                logic [DATA_W-1:0] c = 0, logic [CMP_W-1:0] cc = 0,
                                logic neg = 0, logic [TGT_W-1:0] tgt = 0);
    instr_t it;
    it.kind = k;        it.a_is_var = aiv; it.a_value = a;
    it.b_is_var = biv;  it.b_value = b;    it.c_is_var = civ;
    it.c_value = c;     it.cmp_code = cc;  it.negate = neg;
    it.target_line = tgt;
    return it;
  endfunction

  function automatic logic [DATA_W-1:0] rand_idx();
    case ($urandom_range(0, 19))
      0:       return {$urandom, $urandom};
      1:       return 64'(NVARS) + $urandom_range(0, 3);
      2:       return '1;
      default: return $urandom_range(0, 15);
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] rand_val();
    case ($urandom_range(0, 7))
      0:       return {$urandom, $urandom};
      1:       return {1'b1, 63'd0};
      2:       return {1'b0, {63{1'b1}}};
      3:       return 64'($signed($urandom_range(0, 40)) - 20);
      default: return $urandom_range(0, 200);
    endcase
  endfunction

  // random instruction, mostly legal with pc kept inside the program
  function automatic instr_t rand_instr(logic [PC_W-1:0] lines);
    instr_t      it;
    kind_e       k;
    logic        biv;
    logic [TGT_W-1:0] tgt;
    biv = ($urandom_range(0, 2) == 0);
    tgt = (lines == 0) ? '0 : TGT_W'($urandom_range(0, lines - 1));
    if ($urandom_range(0, 30) == 0) tgt = TGT_W'($urandom);
    k = kind_e'($urandom_range(0, 15));
    if (sb.pc + 2 >= lines && $urandom_range(0, 15) != 0) k = K_GOTO;
    case (k)
      K_POKE, K_PEEK: begin
        it = mk(k, $urandom_range(0, 3) == 0,
                $urandom_range(0, 3) == 0 ? rand_idx() : $urandom_range(0, sb.used + 2),
                biv, biv ? rand_idx() : ($urandom_range(0, 3) == 0 ? rand_val() : '0),
                $urandom_range(0, 1), k == K_PEEK ? rand_idx() : rand_val());
      end
      K_ALLOC:
        it = mk(k, $urandom_range(0, 1), rand_idx(), biv,
                biv ? rand_idx() : ($urandom_range(0, 9) == 0 ? rand_val()
                                    : $urandom_range(0, 60)));
      K_IF:
        it = mk(k, $urandom_range(0, 1), rand_idx(), biv, biv ? rand_idx() : rand_val(),
                0, 0, $urandom_range(0, 7), $urandom_range(0, 1));
      default:
        it = mk(k, $urandom_range(0, 1), rand_idx(), biv, biv ? rand_idx() : rand_val());
    endcase
    it.target_line = tgt;
    // noise on fields the kind ignores
    if (k inside {K_GOTO, K_GOSUB, K_RETURN, K_FLIP, K_END, K_NOP}) begin
      it.c_is_var = $urandom_range(0, 1);
      it.c_value  = {$urandom, $urandom};
      it.cmp_code = $urandom_range(0, 7);
      it.negate   = $urandom_range(0, 1);
    end
    return it;
  endfunction

  // one input beat, with bursts and gaps on the sender side
  task automatic send_instr(input instr_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    kind_d     <= it.kind;
    a_is_var_d <= it.a_is_var;
    a_value_d  <= it.a_value;
    b_is_var_d <= it.b_is_var;
    b_value_d  <= it.b_value;
    c_is_var_d <= it.c_is_var;
    c_value_d  <= it.c_value;
    cmp_code_d <= it.cmp_code;
    negate_d   <= it.negate;
    target_d   <= it.target_line;
    in_valid   <= 1'b1;
    do @(posedge clk_i); while (!in_ready);
    sb.note_input(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // register write while the block is idle
  task automatic write_cfg(input cfg_idx_e idx, input logic [DATA_W-1:0] data);
    drain();
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready);
    sb.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // run random beats under one register setting, pulling pc back first
  task automatic run_phase(input logic [PC_W-1:0] lines, input logic [DATA_W-1:0] seed);
    logic [PC_W-1:0] eff;
    send_instr(mk(K_GOTO, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    write_cfg(CFG_PROGRAM_LINES, lines);
    write_cfg(CFG_RNG_SEED, seed);
    eff = (lines < MAX_LINES) ? lines : PC_W'(MAX_LINES);
    for (int n = 0; n < RAND_ITEMS; n++) send_instr(rand_instr(eff));
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // no lines loaded: execution has already ended
    send_instr(mk(K_NOP, 0, 0, 0, 0));
    write_cfg(CFG_PROGRAM_LINES, 11'h7ff);
    write_cfg(CFG_RNG_SEED, '0);

    // arithmetic corners
    send_instr(mk(K_SET, 0, 0, 0, {1'b0, {63{1'b1}}}));
    send_instr(mk(K_ADD, 0, 0, 0, 1));
    send_instr(mk(K_SET, 0, 1, 0, '1));
    send_instr(mk(K_DIV, 0, 0, 1, 1));
    send_instr(mk(K_SUB, 0, 2, 0, 7));
    send_instr(mk(K_MUL, 0, 2, 0, 64'h0123_4567_89ab_cdef));
    send_instr(mk(K_DIV, 0, 2, 0, 0));
    send_instr(mk(K_SET, 0, 3, 0, 64'(-7)));
    send_instr(mk(K_DIV, 0, 3, 0, 2));
    send_instr(mk(K_RND, 0, 4, 0, 0));
    send_instr(mk(K_RND, 0, 4, 0, {1'b1, 63'd5}));
    send_instr(mk(K_RND, 0, 4, 0, 10));
    send_instr(mk(K_RND, 0, 4, 0, {1'b0, {63{1'b1}}}));
    // out of range destination and source
    send_instr(mk(K_SET, 1, 64, 0, 5));
    send_instr(mk(K_SET, 0, '1, 1, 200));
    // compares, including unknown codes, with and without negate
    for (int c = 0; c < 8; c++)
      send_instr(mk(K_IF, 1, 3, 0, 64'(-7), 0, 0, c, c[0], 40 + c));
    // calls, including a return with an empty stack
    send_instr(mk(K_RETURN, 0, 0, 0, 0));
    send_instr(mk(K_GOSUB, 0, 0, 0, 0, 0, 0, 0, 0, 1023));
    send_instr(mk(K_RETURN, 0, 0, 0, 0));
    // arena: size zero, too large, poke, peek, bad address
    send_instr(mk(K_ALLOC, 0, 5, 0, 0));
    send_instr(mk(K_ALLOC, 0, 6, 0, 2000));
    send_instr(mk(K_ALLOC, 0, 6, 0, 4));
    send_instr(mk(K_POKE, 1, 6, 0, 1, 1, 0));
    send_instr(mk(K_PEEK, 0, 2, 0, 0, 0, 7));
    send_instr(mk(K_PEEK, 0, 0, 0, 0, 0, 8));
    send_instr(mk(K_FLIP, 0, 0, 0, 0));
    send_instr(mk(K_END, 0, 0, 0, 0));
    send_instr(mk(K_GOTO, 0, 0, 0, 0, 0, 0, 0, 0, 10));

    // stack overflow
    for (int n = 0; n < STACK_SZ + 1; n++)
      send_instr(mk(K_GOSUB, 0, 0, 0, 0, 0, 0, 0, 0, 20));

    run_phase(11'd1024, {$urandom, $urandom});
    run_phase(11'd40, '1);
    run_phase(11'd2047, {$urandom, $urandom});
    run_phase(11'd3, 64'd0);
    run_phase(11'd1024, {$urandom, $urandom});

    drain();
    if (sb.errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule

// ===== script_vm_execute_unit.f =====
+incdir+src
src/svmx_pkg.sv
src/svmx_div.sv
src/svmx_ctrl.sv
src/svmx_dp.sv
src/script_vm_execute_unit.sv
src/svmx_checker.sv
tb/tb_script_vm_execute_unit.sv
